[src/oval_arc_point_generator_assert.svh]
// Assertion macros used by the checker of the oval arc point generator.
// Both expect signals named clock and reset in the module that uses them.
`ifndef OVAL_ARC_POINT_GENERATOR_ASSERT_SVH
`define OVAL_ARC_POINT_GENERATOR_ASSERT_SVH

// Antecedent implies consequent in the same cycle, ignored while in reset.
`define OAP_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("oap check failed: implication");

// Consequent holds in the cycle after reset is seen, reset included.
`define OAP_ASSERT_AFTER_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("oap check failed: after reset");

`endif

[src/oap_pkg.sv]
package oap_pkg;

   localparam int INDEX_W    = 7;
   localparam int COUNT_W    = 8;
   localparam int COORD_W    = 16;
   localparam int SIZE_W     = 15;
   localparam int ANGLE_W    = 17;
   localparam int SPAN_W     = 18;
   localparam int PRODUCT_W  = 26;
   localparam int DIVIDEND_W = 24;
   localparam int TURN_W     = 26;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int DEG_UNITS   = 64;
   localparam int HALF_TURN   = 180 * DEG_UNITS;
   localparam int FULL_TURN   = 2 * HALF_TURN;
   localparam int TURN_OFFSET = 800;

   // angle reduction: floor(v / 23040) = floor((v >> 9) / 45)
   localparam int BLOCK_SHIFT      = 9;
   localparam int BLOCK_W          = TURN_W - BLOCK_SHIFT;
   localparam int TURN_RECIP       = 186414;
   localparam int TURN_RECIP_W     = 18;
   localparam int TURN_RECIP_SHIFT = 23;
   localparam int NTURN_W          = 12;
   localparam int RED_W            = 15;
   localparam int BAM_RES          = 45;
   localparam int RES_W            = 6;
   localparam int RES_RECIP        = 46604;
   localparam int RES_RECIP_W      = 16;
   localparam int RES_RECIP_SHIFT  = 21;
   localparam int MDIV_W           = 9;
   localparam int BAM_FRAC_W       = 23;
   localparam int BAM_W            = 32;

   localparam int CORDIC_W    = 32;
   localparam int Z_W         = 34;
   localparam int SCALE_W     = 48;
   localparam int SCALE_SHIFT = 31;
   localparam int SUM_W       = 18;

   localparam logic signed [CORDIC_W-1:0] GAIN_INV = 32'sd652032874;
   localparam logic signed [Z_W-1:0]      Z_QUARTER = 34'sd1073741824;
   localparam logic signed [Z_W-1:0]      Z_HALF    = 34'sd2147483648;
   localparam logic signed [SCALE_W-1:0]  SCALE_ROUND = 48'sd1073741824;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic [COORD_W-1:0] CENTER_RESET = 16'd0;
   localparam logic [SIZE_W-1:0]  SIZE_RESET   = 15'd4096;
   localparam logic [COUNT_W-1:0] COUNT_RESET  = 8'd32;
   localparam logic [ANGLE_W-1:0] START_RESET  = 17'd0;
   localparam logic [ANGLE_W-1:0] END_RESET    = 17'd11520;

   typedef enum logic [2:0] {
      REG_CENTER_X    = 3'd0,
      REG_CENTER_Y    = 3'd1,
      REG_OVAL_WIDTH  = 3'd2,
      REG_OVAL_HEIGHT = 3'd3,
      REG_POINT_COUNT = 3'd4,
      REG_START_ANGLE = 3'd5,
      REG_END_ANGLE   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic [SIZE_W-1:0]  oval_width;
      logic [SIZE_W-1:0]  oval_height;
      logic [COUNT_W-1:0] point_count;
      logic [ANGLE_W-1:0] start_angle;
      logic [ANGLE_W-1:0] end_angle;
   } arc_cfg_type;

   typedef struct packed {
      logic [TURN_W-1:0] angle;
      logic              point_valid;
   } arc_item_type;

   typedef struct packed {
      logic flip;
      logic point_valid;
   } cordic_tag_type;

   typedef logic [BAM_RES-1:0][BAM_FRAC_W-1:0] frac_table_type;

   // floor((r * 2^24 + 45) / 90): fraction of a turn for a residue of 45
   function automatic frac_table_type build_bam_frac();
      frac_table_type    t;
      longint unsigned   v;
      for (int r = 0; r < BAM_RES; r++) begin
         v = ((longint'(r) << 24) + BAM_RES) / (2 * BAM_RES);
         t[r] = BAM_FRAC_W'(v);
      end
      return t;
   endfunction

   localparam frac_table_type BAM_FRAC = build_bam_frac();

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] v;
      case (i)
         0:  v = 32'd536870912;
         1:  v = 32'd316933406;
         2:  v = 32'd167458907;
         3:  v = 32'd85004756;
         4:  v = 32'd42667331;
         5:  v = 32'd21354465;
         6:  v = 32'd10679838;
         7:  v = 32'd5340245;
         8:  v = 32'd2670163;
         9:  v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         24: v = 32'd41;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

[src/oap_front.sv]
module oap_front #(
   parameter int MAX_POINTS = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  oap_pkg::arc_cfg_type            cfg,
   input  logic                            take,
   input  logic [oap_pkg::INDEX_W-1:0]     point_index,
   output logic                            push,
   output oap_pkg::arc_item_type           item
);

   localparam int STEPS = oap_pkg::DIVIDEND_W;

   logic [oap_pkg::COUNT_W-1:0]           count_eff;
   logic [oap_pkg::COUNT_W-1:0]           den;
   logic                                  point_ok;
   logic signed [oap_pkg::SPAN_W-1:0]     span;
   logic signed [oap_pkg::PRODUCT_W-1:0]  num;
   logic signed [oap_pkg::PRODUCT_W-1:0]  mag;

   logic                                  s0_valid_ff, s0_ok_ff, s0_neg_ff;
   logic [oap_pkg::DIVIDEND_W-1:0]        s0_mag_ff;
   logic                                  s1_valid_ff, s1_ok_ff, s1_neg_ff;
   logic [oap_pkg::DIVIDEND_W-1:0]        s1_dividend_ff;
   logic [oap_pkg::DIVIDEND_W-1:0]        s1_dividend_in;

   logic                                  dv_valid_ff [STEPS];
   logic                                  dv_ok_ff    [STEPS];
   logic                                  dv_neg_ff   [STEPS];
   logic [oap_pkg::COUNT_W-1:0]           dv_rem_ff   [STEPS];
   logic [oap_pkg::DIVIDEND_W-1:0]        dv_work_ff  [STEPS];

   logic                                  src_valid [STEPS];
   logic                                  src_ok    [STEPS];
   logic                                  src_neg   [STEPS];
   logic [oap_pkg::COUNT_W-1:0]           src_rem   [STEPS];
   logic [oap_pkg::DIVIDEND_W-1:0]        src_work  [STEPS];
   logic [oap_pkg::COUNT_W-1:0]           rem_in    [STEPS];
   logic [oap_pkg::DIVIDEND_W-1:0]        work_in   [STEPS];

   logic                                  push_ff;
   oap_pkg::arc_item_type                 item_ff;
   oap_pkg::arc_item_type                 item_in;
   logic signed [oap_pkg::TURN_W-1:0]     quot;

   always_comb begin
      if (int'(cfg.point_count) > MAX_POINTS) begin
         count_eff = oap_pkg::COUNT_W'(MAX_POINTS);
      end else begin
         count_eff = cfg.point_count;
      end
      den = (count_eff >= oap_pkg::COUNT_W'(2)) ? count_eff - oap_pkg::COUNT_W'(1)
                                                : oap_pkg::COUNT_W'(1);
      point_ok = (count_eff != '0) && ({1'b0, point_index} < count_eff);
      span = oap_pkg::SPAN_W'($signed(cfg.end_angle))
           - oap_pkg::SPAN_W'($signed(cfg.start_angle));
      num = oap_pkg::PRODUCT_W'(span) * $signed({1'b0, point_index});
      mag = (num < 0) ? -num : num;
      s1_dividend_in = s0_mag_ff + oap_pkg::DIVIDEND_W'(den >> 1);
   end

   // Restoring division, one quotient bit per stage; the work word shifts
   // dividend bits out at the top and quotient bits in at the bottom.
   always_comb begin
      logic [oap_pkg::COUNT_W:0] trial;
      logic                      ge;
      src_valid[0] = s1_valid_ff;
      src_ok[0]    = s1_ok_ff;
      src_neg[0]   = s1_neg_ff;
      src_rem[0]   = '0;
      src_work[0]  = s1_dividend_ff;
      for (int j = 1; j < STEPS; j++) begin
         src_valid[j] = dv_valid_ff[j-1];
         src_ok[j]    = dv_ok_ff[j-1];
         src_neg[j]   = dv_neg_ff[j-1];
         src_rem[j]   = dv_rem_ff[j-1];
         src_work[j]  = dv_work_ff[j-1];
      end
      for (int j = 0; j < STEPS; j++) begin
         trial = {src_rem[j], src_work[j][oap_pkg::DIVIDEND_W-1]};
         ge    = trial >= {1'b0, den};
         rem_in[j]  = ge ? oap_pkg::COUNT_W'(trial - {1'b0, den})
                         : trial[oap_pkg::COUNT_W-1:0];
         work_in[j] = {src_work[j][oap_pkg::DIVIDEND_W-2:0], ge};
      end
   end

   always_comb begin
      quot = $signed({2'b00, dv_work_ff[STEPS-1]});
      item_in.angle = oap_pkg::TURN_W'($signed(cfg.start_angle))
                    + (dv_neg_ff[STEPS-1] ? -quot : quot);
      item_in.point_valid = dv_ok_ff[STEPS-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         push_ff     <= 1'b0;
         for (int j = 0; j < STEPS; j++) begin
            dv_valid_ff[j] <= 1'b0;
         end
      end else begin
         s0_valid_ff <= take;
         s1_valid_ff <= s0_valid_ff;
         push_ff     <= dv_valid_ff[STEPS-1];
         for (int j = 0; j < STEPS; j++) begin
            dv_valid_ff[j] <= src_valid[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      s0_ok_ff       <= point_ok;
      s0_neg_ff      <= num < 0;
      s0_mag_ff      <= mag[oap_pkg::DIVIDEND_W-1:0];
      s1_ok_ff       <= s0_ok_ff;
      s1_neg_ff      <= s0_neg_ff;
      s1_dividend_ff <= s1_dividend_in;
      for (int j = 0; j < STEPS; j++) begin
         dv_ok_ff[j]   <= src_ok[j];
         dv_neg_ff[j]  <= src_neg[j];
         dv_rem_ff[j]  <= rem_in[j];
         dv_work_ff[j] <= work_in[j];
      end
      item_ff <= item_in;
   end

   assign push = push_ff;
   assign item = item_ff;

endmodule

[src/oap_queue.sv]
module oap_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  oap_pkg::arc_item_type  push_item,
   input  logic                   pop,
   output oap_pkg::arc_item_type  pop_item,
   output logic                   not_empty,
   output logic                   full
);

   oap_pkg::arc_item_type              slots_ff [oap_pkg::QUEUE_DEPTH];
   logic [oap_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [oap_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                               do_pop;

   assign do_pop    = pop && (count_ff != '0);
   assign not_empty = count_ff != '0;
   assign full      = count_ff == oap_pkg::QUEUE_CNT_W'(oap_pkg::QUEUE_DEPTH);
   assign pop_item  = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + oap_pkg::QUEUE_CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - oap_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + oap_pkg::QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + oap_pkg::QUEUE_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[src/oap_cordic.sv]
module oap_cordic #(
   parameter int STAGES = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [oap_pkg::Z_W-1:0]        in_z,
   input  oap_pkg::cordic_tag_type               in_tag,
   output logic                                  out_valid,
   output logic signed [oap_pkg::CORDIC_W-1:0]   out_x,
   output logic signed [oap_pkg::CORDIC_W-1:0]   out_y,
   output oap_pkg::cordic_tag_type               out_tag
);

   logic                                  valid_ff [STAGES];
   oap_pkg::cordic_tag_type               tag_ff   [STAGES];
   logic signed [oap_pkg::CORDIC_W-1:0]   x_ff     [STAGES];
   logic signed [oap_pkg::CORDIC_W-1:0]   y_ff     [STAGES];
   logic signed [oap_pkg::Z_W-1:0]        z_ff     [STAGES];

   logic                                  src_valid [STAGES];
   oap_pkg::cordic_tag_type               src_tag   [STAGES];
   logic signed [oap_pkg::CORDIC_W-1:0]   src_x     [STAGES];
   logic signed [oap_pkg::CORDIC_W-1:0]   src_y     [STAGES];
   logic signed [oap_pkg::Z_W-1:0]        src_z     [STAGES];
   logic signed [oap_pkg::CORDIC_W-1:0]   x_in      [STAGES];
   logic signed [oap_pkg::CORDIC_W-1:0]   y_in      [STAGES];
   logic signed [oap_pkg::Z_W-1:0]        z_in      [STAGES];

   always_comb begin
      logic signed [oap_pkg::CORDIC_W-1:0] dx, dy;
      logic signed [oap_pkg::Z_W-1:0]      step;
      src_valid[0] = in_valid;
      src_tag[0]   = in_tag;
      src_x[0]     = oap_pkg::GAIN_INV;
      src_y[0]     = '0;
      src_z[0]     = in_z;
      for (int i = 1; i < STAGES; i++) begin
         src_valid[i] = valid_ff[i-1];
         src_tag[i]   = tag_ff[i-1];
         src_x[i]     = x_ff[i-1];
         src_y[i]     = y_ff[i-1];
         src_z[i]     = z_ff[i-1];
      end
      for (int i = 0; i < STAGES; i++) begin
         dx   = src_y[i] >>> i;
         dy   = src_x[i] >>> i;
         step = $signed(oap_pkg::Z_W'(oap_pkg::atan_turn(i)));
         if (src_z[i] >= 0) begin
            x_in[i] = src_x[i] - dx;
            y_in[i] = src_y[i] + dy;
            z_in[i] = src_z[i] - step;
         end else begin
            x_in[i] = src_x[i] + dx;
            y_in[i] = src_y[i] - dy;
            z_in[i] = src_z[i] + step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            valid_ff[i] <= src_valid[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         tag_ff[i] <= src_tag[i];
         x_ff[i]   <= x_in[i];
         y_ff[i]   <= y_in[i];
         z_ff[i]   <= z_in[i];
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_tag   = tag_ff[STAGES-1];
   assign out_x     = x_ff[STAGES-1];
   assign out_y     = y_ff[STAGES-1];

endmodule

[src/oap_back.sv]
module oap_back #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  oap_pkg::arc_cfg_type                 cfg,
   input  logic                                 take,
   input  oap_pkg::arc_item_type                item,
   output logic                                 rsp_strobe,
   output logic [oap_pkg::COORD_W-1:0]          point_x,
   output logic [oap_pkg::COORD_W-1:0]          point_y,
   output logic                                 point_valid
);

   // angle reduction pipeline
   logic                                  b0_valid_ff, b0_pv_ff;
   logic [oap_pkg::TURN_W-1:0]            b0_vp_ff, b0_vp_in;
   logic                                  b1_valid_ff, b1_pv_ff;
   logic [oap_pkg::TURN_W-1:0]            b1_vp_ff;
   logic [oap_pkg::NTURN_W-1:0]           b1_n_ff, b1_n_in;
   logic                                  b2_valid_ff, b2_pv_ff;
   logic [oap_pkg::RED_W-1:0]             b2_a_ff, b2_a_in;
   logic                                  b3_valid_ff, b3_pv_ff;
   logic [oap_pkg::RED_W-1:0]             b3_a_ff;
   logic [oap_pkg::MDIV_W-1:0]            b3_m_ff, b3_m_in;
   logic                                  b4_valid_ff, b4_pv_ff;
   logic [oap_pkg::BAM_W-1:0]             b4_bam_ff, b4_bam_in;
   logic                                  b5_valid_ff;
   oap_pkg::cordic_tag_type               b5_tag_ff, b5_tag_in;
   logic signed [oap_pkg::Z_W-1:0]        b5_z_ff, b5_z_in;

   logic [oap_pkg::BLOCK_W+oap_pkg::TURN_RECIP_W-1:0]  turn_prod;
   logic [oap_pkg::RED_W+oap_pkg::RES_RECIP_W-1:0]     res_prod;
   logic [oap_pkg::RED_W-1:0]                          residue;
   logic signed [oap_pkg::Z_W-1:0]                     z_wide;

   // CORDIC and scaling
   logic                                  cd_valid;
   logic signed [oap_pkg::CORDIC_W-1:0]   cd_x, cd_y;
   oap_pkg::cordic_tag_type               cd_tag;
   logic signed [oap_pkg::CORDIC_W-1:0]   cos_v, sin_v;
   logic                                  b6_valid_ff, b6_pv_ff;
   logic signed [oap_pkg::SCALE_W-1:0]    b6_px_ff, b6_py_ff, b6_px_in, b6_py_in;
   logic                                  out_strobe_ff, out_pv_ff;
   logic [oap_pkg::COORD_W-1:0]           out_x_ff, out_y_ff, out_x_in, out_y_in;

   function automatic logic [oap_pkg::COORD_W-1:0] place(
      input logic signed [oap_pkg::SCALE_W-1:0] p,
      input logic [oap_pkg::COORD_W-1:0]        center
   );
      logic signed [oap_pkg::SCALE_W-1:0] t;
      logic signed [oap_pkg::SUM_W-1:0]   s;
      logic [oap_pkg::COORD_W-1:0]        r;
      t = (p + oap_pkg::SCALE_ROUND) >>> oap_pkg::SCALE_SHIFT;
      s = oap_pkg::SUM_W'(t) + oap_pkg::SUM_W'($signed(center));
      if (s > oap_pkg::SUM_W'(32767)) begin
         r = 16'h7fff;
      end else if (s < -oap_pkg::SUM_W'(32768)) begin
         r = 16'h8000;
      end else begin
         r = s[oap_pkg::COORD_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      // offset by whole turns to make the angle non-negative
      b0_vp_in = item.angle
               + oap_pkg::TURN_W'(oap_pkg::FULL_TURN * oap_pkg::TURN_OFFSET);
      turn_prod = (oap_pkg::BLOCK_W + oap_pkg::TURN_RECIP_W)'(
                     b0_vp_ff[oap_pkg::TURN_W-1:oap_pkg::BLOCK_SHIFT])
                * (oap_pkg::BLOCK_W + oap_pkg::TURN_RECIP_W)'(oap_pkg::TURN_RECIP);
      b1_n_in = oap_pkg::NTURN_W'(turn_prod >> oap_pkg::TURN_RECIP_SHIFT);
      b2_a_in = oap_pkg::RED_W'(b1_vp_ff - oap_pkg::TURN_W'(b1_n_ff)
                                         * oap_pkg::TURN_W'(oap_pkg::FULL_TURN));
      res_prod = (oap_pkg::RED_W + oap_pkg::RES_RECIP_W)'(b2_a_ff)
               * (oap_pkg::RED_W + oap_pkg::RES_RECIP_W)'(oap_pkg::RES_RECIP);
      b3_m_in = oap_pkg::MDIV_W'(res_prod >> oap_pkg::RES_RECIP_SHIFT);
      residue = b3_a_ff - oap_pkg::RED_W'(b3_m_ff) * oap_pkg::RED_W'(oap_pkg::BAM_RES);
      b4_bam_in = {b3_m_ff, oap_pkg::BAM_FRAC[residue[oap_pkg::RES_W-1:0]]};
      // fold the left half plane onto the right one and negate at the end
      z_wide = oap_pkg::Z_W'($signed(b4_bam_ff));
      b5_tag_in.point_valid = b4_pv_ff;
      b5_tag_in.flip = (z_wide > oap_pkg::Z_QUARTER) || (z_wide < -oap_pkg::Z_QUARTER);
      if (!b5_tag_in.flip) begin
         b5_z_in = z_wide;
      end else if (z_wide > 0) begin
         b5_z_in = z_wide - oap_pkg::Z_HALF;
      end else begin
         b5_z_in = z_wide + oap_pkg::Z_HALF;
      end
   end

   oap_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b5_valid_ff),
      .in_z      (b5_z_ff),
      .in_tag    (b5_tag_ff),
      .out_valid (cd_valid),
      .out_x     (cd_x),
      .out_y     (cd_y),
      .out_tag   (cd_tag)
   );

   always_comb begin
      cos_v = cd_tag.flip ? -cd_x : cd_x;
      sin_v = cd_tag.flip ? -cd_y : cd_y;
      b6_px_in = oap_pkg::SCALE_W'(cos_v)
               * oap_pkg::SCALE_W'($signed({1'b0, cfg.oval_width}));
      b6_py_in = oap_pkg::SCALE_W'(sin_v)
               * oap_pkg::SCALE_W'($signed({1'b0, cfg.oval_height}));
      out_x_in = b6_pv_ff ? place(b6_px_ff, cfg.center_x) : '0;
      out_y_in = b6_pv_ff ? place(b6_py_ff, cfg.center_y) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff   <= 1'b0;
         b1_valid_ff   <= 1'b0;
         b2_valid_ff   <= 1'b0;
         b3_valid_ff   <= 1'b0;
         b4_valid_ff   <= 1'b0;
         b5_valid_ff   <= 1'b0;
         b6_valid_ff   <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         b0_valid_ff   <= take;
         b1_valid_ff   <= b0_valid_ff;
         b2_valid_ff   <= b1_valid_ff;
         b3_valid_ff   <= b2_valid_ff;
         b4_valid_ff   <= b3_valid_ff;
         b5_valid_ff   <= b4_valid_ff;
         b6_valid_ff   <= cd_valid;
         out_strobe_ff <= b6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b0_pv_ff  <= item.point_valid;
      b0_vp_ff  <= b0_vp_in;
      b1_pv_ff  <= b0_pv_ff;
      b1_vp_ff  <= b0_vp_ff;
      b1_n_ff   <= b1_n_in;
      b2_pv_ff  <= b1_pv_ff;
      b2_a_ff   <= b2_a_in;
      b3_pv_ff  <= b2_pv_ff;
      b3_a_ff   <= b2_a_ff;
      b3_m_ff   <= b3_m_in;
      b4_pv_ff  <= b3_pv_ff;
      b4_bam_ff <= b4_bam_in;
      b5_tag_ff <= b5_tag_in;
      b5_z_ff   <= b5_z_in;
      b6_pv_ff  <= cd_tag.point_valid;
      b6_px_ff  <= b6_px_in;
      b6_py_ff  <= b6_py_in;
      out_pv_ff <= b6_pv_ff;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
   end

   assign rsp_strobe  = out_strobe_ff;
   assign point_x     = out_x_ff;
   assign point_y     = out_y_ff;
   assign point_valid = out_pv_ff;

endmodule

[src/oval_arc_point_generator.sv]
// Oval arc point generator. Program the centre, width, height, point count and
// start and end angles over the register port while no request is in flight,
// then pulse start with a point index; the point's x and y (Q4.12, saturated)
// come back on rsp_strobe in request order, one point per clock when start is
// held high and busy is low. Each passes through the 24-stage pipelined divider
// that spaces the points along the arc, the angle reduction stages and one
// CORDIC stage per iteration. busy only rises if the queue between the step and
// rotation pipelines fills, which does not happen in normal use. Results cannot
// be held off: take each on its strobe cycle.
module oval_arc_point_generator #(
   parameter int MAX_POINTS    = 128,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [oap_pkg::INDEX_W-1:0]         req_point_index,
   output logic                                rsp_strobe,
   output logic [oap_pkg::COORD_W-1:0]         rsp_point_x,
   output logic [oap_pkg::COORD_W-1:0]         rsp_point_y,
   output logic                                rsp_point_valid,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [oap_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [oap_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [oap_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   oap_pkg::arc_cfg_type    cfg_ff;
   oap_pkg::csr_index_type  csr_index;
   logic                    csr_write;
   logic                    take;
   logic                    push;
   oap_pkg::arc_item_type   push_item;
   oap_pkg::arc_item_type   pop_item;
   logic                    not_empty;
   logic                    full;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = oap_pkg::csr_index_type'(paddr[oap_pkg::CSR_ADDR_W-1:2]);
   assign busy      = full;
   assign take      = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x    <= oap_pkg::CENTER_RESET;
         cfg_ff.center_y    <= oap_pkg::CENTER_RESET;
         cfg_ff.oval_width  <= oap_pkg::SIZE_RESET;
         cfg_ff.oval_height <= oap_pkg::SIZE_RESET;
         cfg_ff.point_count <= oap_pkg::COUNT_RESET;
         cfg_ff.start_angle <= oap_pkg::START_RESET;
         cfg_ff.end_angle   <= oap_pkg::END_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            oap_pkg::REG_CENTER_X:    cfg_ff.center_x    <= pwdata[oap_pkg::COORD_W-1:0];
            oap_pkg::REG_CENTER_Y:    cfg_ff.center_y    <= pwdata[oap_pkg::COORD_W-1:0];
            oap_pkg::REG_OVAL_WIDTH:  cfg_ff.oval_width  <= pwdata[oap_pkg::SIZE_W-1:0];
            oap_pkg::REG_OVAL_HEIGHT: cfg_ff.oval_height <= pwdata[oap_pkg::SIZE_W-1:0];
            oap_pkg::REG_POINT_COUNT: cfg_ff.point_count <= pwdata[oap_pkg::COUNT_W-1:0];
            oap_pkg::REG_START_ANGLE: cfg_ff.start_angle <= pwdata[oap_pkg::ANGLE_W-1:0];
            oap_pkg::REG_END_ANGLE:   cfg_ff.end_angle   <= pwdata[oap_pkg::ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         oap_pkg::REG_CENTER_X:    prdata = oap_pkg::CSR_DATA_W'(cfg_ff.center_x);
         oap_pkg::REG_CENTER_Y:    prdata = oap_pkg::CSR_DATA_W'(cfg_ff.center_y);
         oap_pkg::REG_OVAL_WIDTH:  prdata = oap_pkg::CSR_DATA_W'(cfg_ff.oval_width);
         oap_pkg::REG_OVAL_HEIGHT: prdata = oap_pkg::CSR_DATA_W'(cfg_ff.oval_height);
         oap_pkg::REG_POINT_COUNT: prdata = oap_pkg::CSR_DATA_W'(cfg_ff.point_count);
         oap_pkg::REG_START_ANGLE: prdata = oap_pkg::CSR_DATA_W'(cfg_ff.start_angle);
         oap_pkg::REG_END_ANGLE:   prdata = oap_pkg::CSR_DATA_W'(cfg_ff.end_angle);
         default:                  prdata = '0;
      endcase
   end

   oap_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .take        (take),
      .point_index (req_point_index),
      .push        (push),
      .item        (push_item)
   );

   oap_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (not_empty),
      .pop_item  (pop_item),
      .not_empty (not_empty),
      .full      (full)
   );

   oap_back #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .take        (not_empty),
      .item        (pop_item),
      .rsp_strobe  (rsp_strobe),
      .point_x     (rsp_point_x),
      .point_y     (rsp_point_y),
      .point_valid (rsp_point_valid)
   );

endmodule

[src/oap_checker.sv]
`include "oval_arc_point_generator_assert.svh"

module oap_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_strobe,
   input logic [oap_pkg::COORD_W-1:0]    rsp_point_x,
   input logic [oap_pkg::COORD_W-1:0]    rsp_point_y,
   input logic                           rsp_point_valid,
   input logic                           pready
);

   logic at_origin;

   assign at_origin = (rsp_point_x == '0) && (rsp_point_y == '0);

   // no result may follow a reset cycle
   `OAP_ASSERT_AFTER_RESET(a_quiet_after_reset, !rsp_strobe)

   // an invalid point reports the origin
   `OAP_ASSERT_IMPLY(a_invalid_is_zero, rsp_strobe && !rsp_point_valid, at_origin)

   `OAP_ASSERT_IMPLY(a_ready_high, 1'b1, pready)

endmodule

bind oval_arc_point_generator oap_checker u_oap_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_strobe      (rsp_strobe),
   .rsp_point_x     (rsp_point_x),
   .rsp_point_y     (rsp_point_y),
   .rsp_point_valid (rsp_point_valid),
   .pready          (pready)
);

[verif/tb_top.sv]
module tb_top;

   localparam int N_STAGES   = 16;
   localparam int CAPACITY   = 128;
   localparam int SETTLE     = 80;
   localparam int LIMIT      = 400000;

   typedef struct packed {
      logic [oap_pkg::COORD_W-1:0] x;
      logic [oap_pkg::COORD_W-1:0] y;
      logic                        valid;
   } arc_point_type;

   typedef struct {
      int            cfg_id;
      int            index;
      bit            typed;
      arc_point_type want;
   } stim_row_type;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [oap_pkg::INDEX_W-1:0]    req_point_index;
   logic                           rsp_strobe;
   logic [oap_pkg::COORD_W-1:0]    rsp_point_x;
   logic [oap_pkg::COORD_W-1:0]    rsp_point_y;
   logic                           rsp_point_valid;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [oap_pkg::CSR_ADDR_W-1:0] paddr;
   logic [oap_pkg::CSR_DATA_W-1:0] pwdata;
   logic [oap_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   oap_pkg::arc_cfg_type  arc_cfg;
   arc_point_type         pending_points[$];
   int                    mismatches;
   int                    cycles;
   int                    idle_pct;
   longint                atan_units[N_STAGES];

   oval_arc_point_generator DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_point_index(req_point_index),
      .rsp_strobe(rsp_strobe), .rsp_point_x(rsp_point_x),
      .rsp_point_y(rsp_point_y), .rsp_point_valid(rsp_point_valid),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycles, msg);
      mismatches++;
   endtask

   function automatic longint clamp16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint project(input longint trig, input longint size,
                                      input longint centre);
      longint p;
      p = trig * size + 64'sd1073741824;
      return clamp16((p >>> 31) + centre);
   endfunction

   function automatic arc_point_type arc_point(input oap_pkg::arc_cfg_type c,
                                               input logic [oap_pkg::INDEX_W-1:0] idx);
      arc_point_type r;
      longint cnt, st, en, den, num, mag, q, a, bam, z, x, y, dx, dy;
      bit     flip;
      r = '0;
      cnt = (c.point_count > CAPACITY) ? CAPACITY : c.point_count;
      if (cnt < 1 || idx >= cnt) return r;
      st = longint'(signed'(c.start_angle));
      en = longint'(signed'(c.end_angle));
      den = (cnt >= 2) ? cnt - 1 : 1;
      num = (en - st) * longint'(idx);
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      if (num < 0) q = -q;
      a = (st + q) % oap_pkg::FULL_TURN;
      if (a < 0) a += oap_pkg::FULL_TURN;
      bam = ((a << 32) + oap_pkg::HALF_TURN) / oap_pkg::FULL_TURN;
      bam = bam & 64'hFFFF_FFFF;
      z = (bam >= 64'sd2147483648) ? bam - 64'sd4294967296 : bam;
      flip = 0;
      if (z > 64'sd1073741824 || z < -64'sd1073741824) begin
         flip = 1;
         z = (z > 0) ? z - 64'sd2147483648 : z + 64'sd2147483648;
      end
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < N_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_units[i];
         end else begin
            x += dx; y -= dy; z += atan_units[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      r.x = oap_pkg::COORD_W'(project(x, c.oval_width, longint'(signed'(c.center_x))));
      r.y = oap_pkg::COORD_W'(project(y, c.oval_height, longint'(signed'(c.center_y))));
      r.valid = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin
      arc_point_type want;
      if (!reset && rsp_strobe) begin
         if (pending_points.size() == 0) begin
            report_mismatch("point with no request outstanding");
         end else begin
            want = pending_points.pop_front();
            if (rsp_point_valid !== want.valid)
               report_mismatch($sformatf("valid %b, want %b", rsp_point_valid, want.valid));
            if (rsp_point_x !== want.x)
               report_mismatch($sformatf("x %h, want %h", rsp_point_x, want.x));
            if (rsp_point_y !== want.y)
               report_mismatch($sformatf("y %h, want %h", rsp_point_y, want.y));
         end
      end
   end

   task automatic write_reg(input oap_pkg::csr_index_type r, input logic [31:0] v);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {r, 2'b00}; pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic load_arc(input oap_pkg::arc_cfg_type c);
      write_reg(oap_pkg::REG_CENTER_X, 32'(c.center_x));
      write_reg(oap_pkg::REG_CENTER_Y, 32'(c.center_y));
      write_reg(oap_pkg::REG_OVAL_WIDTH, 32'(c.oval_width));
      write_reg(oap_pkg::REG_OVAL_HEIGHT, 32'(c.oval_height));
      write_reg(oap_pkg::REG_POINT_COUNT, 32'(c.point_count));
      write_reg(oap_pkg::REG_START_ANGLE, 32'(c.start_angle));
      write_reg(oap_pkg::REG_END_ANGLE, 32'(c.end_angle));
      arc_cfg = c;
   endtask

   // hold until every point has come back, then let the pipeline empty
   task automatic drain();
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic request_point(input logic [oap_pkg::INDEX_W-1:0] idx, input bit typed,
                                input arc_point_type want);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_point_index <= idx;
      do @(posedge clock); while (busy);
      pending_points.push_back(typed ? want : arc_point(arc_cfg, idx));
   endtask

   function automatic oap_pkg::arc_cfg_type mk_cfg(input int cx, input int cy, input int w,
                                                   input int h, input int n, input int st,
                                                   input int en);
      oap_pkg::arc_cfg_type c;
      c.center_x = oap_pkg::COORD_W'(cx); c.center_y = oap_pkg::COORD_W'(cy);
      c.oval_width = oap_pkg::SIZE_W'(w); c.oval_height = oap_pkg::SIZE_W'(h);
      c.point_count = oap_pkg::COUNT_W'(n);
      c.start_angle = oap_pkg::ANGLE_W'(st); c.end_angle = oap_pkg::ANGLE_W'(en);
      return c;
   endfunction

   function automatic oap_pkg::arc_cfg_type random_arc();
      oap_pkg::arc_cfg_type c;
      c.center_x = oap_pkg::COORD_W'($urandom);
      c.center_y = oap_pkg::COORD_W'($urandom);
      if ($urandom_range(3) == 0) begin
         c.center_x = oap_pkg::COORD_W'($urandom_range(8191)) - 16'd4096;
         c.center_y = oap_pkg::COORD_W'($urandom_range(8191)) - 16'd4096;
      end
      c.oval_width = oap_pkg::SIZE_W'($urandom);
      c.oval_height = oap_pkg::SIZE_W'($urandom);
      case ($urandom_range(5))
         0: c.point_count = oap_pkg::COUNT_W'($urandom);
         1: c.point_count = oap_pkg::COUNT_W'($urandom_range(3));
         default: c.point_count = oap_pkg::COUNT_W'($urandom_range(128, 2));
      endcase
      c.start_angle = oap_pkg::ANGLE_W'($urandom);
      c.end_angle = oap_pkg::ANGLE_W'($urandom);
      if ($urandom_range(1) == 0) begin
         c.start_angle = oap_pkg::ANGLE_W'($urandom_range(92160)) - 17'd46080;
         c.end_angle = oap_pkg::ANGLE_W'($urandom_range(92160)) - 17'd46080;
      end
      return c;
   endfunction

   oap_pkg::arc_cfg_type arc_sets[5];
   stim_row_type         rows[$];
   arc_point_type        blank;

   initial begin
      int cur_set;
      int cnt;
      logic [oap_pkg::INDEX_W-1:0] idx;
      atan_units = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                     10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                     83443, 41722, 20861};
      reset = 1'b1; start = 1'b0; req_point_index = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      mismatches = 0; cycles = 0; idle_pct = 0; blank = '0;
      arc_cfg = mk_cfg(0, 0, 4096, 4096, 32, 0, 11520);

      arc_sets[0] = arc_cfg;
      arc_sets[1] = mk_cfg(32767, -32768, 32767, 32767, 0, -46080, 46080);
      arc_sets[2] = mk_cfg(-4096, 4096, 8192, 0, 1, 65535, -65536);
      arc_sets[3] = mk_cfg(-32768, 32767, 0, 32767, 255, -65536, 65535);
      arc_sets[4] = mk_cfg(32767, 32767, 32767, 32767, 128, 46080, -46080);

      rows = '{
         '{0, 0, 0, blank}, '{0, 31, 0, blank}, '{0, 16, 0, blank},
         '{0, 32, 1, blank}, '{0, 127, 1, blank}, '{0, 1, 0, blank},
         '{1, 0, 1, blank}, '{1, 127, 1, blank}, '{1, 85, 1, blank},
         '{2, 0, 0, blank}, '{2, 1, 1, blank}, '{2, 127, 1, blank},
         '{3, 0, 0, blank}, '{3, 127, 0, blank}, '{3, 64, 0, blank},
         '{3, 42, 0, blank}, '{4, 0, 0, blank}, '{4, 127, 0, blank},
         '{4, 63, 0, blank}, '{4, 100, 0, blank}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur_set = 0;
      foreach (rows[k]) begin
         if (rows[k].cfg_id != cur_set) begin
            start <= 1'b0;
            @(posedge clock);
            drain();
            cur_set = rows[k].cfg_id;
            load_arc(arc_sets[cur_set]);
         end
         request_point(oap_pkg::INDEX_W'(rows[k].index), rows[k].typed, rows[k].want);
      end

      // random phases: idle rate cycles through none, 67 and 24 percent
      for (int ph = 0; ph < 6; ph++) begin
         start <= 1'b0;
         @(posedge clock);
         drain();
         load_arc(ph == 5 ? arc_sets[4] : random_arc());
         idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 67 : 24;
         cnt = (arc_cfg.point_count > CAPACITY) ? CAPACITY : arc_cfg.point_count;
         for (int n = 0; n < 105; n++) begin
            if (cnt > 0 && $urandom_range(9) < 8)
               idx = oap_pkg::INDEX_W'($urandom_range(cnt - 1));
            else
               idx = oap_pkg::INDEX_W'($urandom);
            request_point(idx, 1'b0, blank);
         end
      end
      start <= 1'b0;
      @(posedge clock);
      drain();

      if (mismatches == 0 && pending_points.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/oap_pkg.sv
src/oap_front.sv
src/oap_queue.sv
src/oap_cordic.sv
src/oap_back.sv
src/oval_arc_point_generator.sv
src/oap_checker.sv
verif/tb_top.sv
